// ----- design/assert_macros.svh -----
// Assertion macros used by the allocator datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define FEA_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("allocator invariant violated");
`define FEA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator sequence violated");
`else
`define FEA_ASSERT(lbl, cond)
`define FEA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/fea_pkg.sv -----
// Types and constants of the free extent allocator.
package fea_pkg;
  localparam int FREE_SLOTS = 16;
  localparam int IW = $clog2(FREE_SLOTS);
  localparam int CW = $clog2(FREE_SLOTS + 1);
  localparam int AW = 3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;

  localparam logic REG_START = 1'b0;
  localparam logic REG_END   = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] req_size;
    logic [31:0] block_address;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [1:0]  status;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_TSCAN, S_FSCAN, S_DROP,
    S_PSCAN, S_INSERT, S_MSTART, S_MSCAN, S_DONE
  } fea_state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic tscan;
    logic fscan;
    logic drop;
    logic pscan;
    logic insert;
    logic mstart;
    logic mstep;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic bad;
    logic is_free;
    logic full;
    logic tail_ok;
    logic scan_end;
    logic tmatch;
    logic fit;
    logic ple;
    logic need;
    logic pend;
    logic out_free;
  } dp_stat_t;
endpackage

// ----- design/fea_ctrl.sv -----
// Command sequencer of the free extent allocator.
module fea_ctrl import fea_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t st,
  output ctl_cmd_t cmd
);
  fea_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (st.bad) state_nxt = S_DONE;
        else if (st.is_free) state_nxt = st.full ? S_DONE : S_PSCAN;
        else state_nxt = st.tail_ok ? S_TSCAN : S_FSCAN;
      end
      S_TSCAN: begin
        if (st.tmatch) state_nxt = S_DROP;
        else if (st.scan_end) state_nxt = (st.need && !st.full) ? S_PSCAN : S_DONE;
      end
      S_FSCAN: begin
        if (st.scan_end) state_nxt = S_DONE;
        else if (st.fit) state_nxt = S_DROP;
      end
      S_DROP: begin
        state_nxt = st.pend ? S_PSCAN : S_DONE;
      end
      S_PSCAN: begin
        if (st.scan_end || !st.ple) state_nxt = S_INSERT;
      end
      S_INSERT: begin
        state_nxt = st.is_free ? S_MSTART : S_DONE;
      end
      S_MSTART: begin
        state_nxt = S_MSCAN;
      end
      S_MSCAN: begin
        if (st.scan_end) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_CHECK:  cmd.check = 1'b1;
      S_TSCAN:  cmd.tscan = 1'b1;
      S_FSCAN:  cmd.fscan = 1'b1;
      S_DROP:   cmd.drop = 1'b1;
      S_PSCAN:  cmd.pscan = 1'b1;
      S_INSERT: cmd.insert = 1'b1;
      S_MSTART: cmd.mstart = 1'b1;
      S_MSCAN:  cmd.mstep = 1'b1;
      S_DONE:   cmd.finish = st.out_free;
      default:  cmd = '0;
    endcase
  end
endmodule

// ----- design/fea_dp.sv -----
// Extent table, tail pointer, region registers and result register.
`include "assert_macros.svh"
module fea_dp import fea_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  ctl_cmd_t        cmd,
  output dp_stat_t        st,
  input  in_word_t        in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_word_t       out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [AW-1:0]   paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata
);
  logic [31:0] est_r [FREE_SLOTS];
  logic [31:0] eln_r [FREE_SLOTS];
  logic [31:0] est_nxt [FREE_SLOTS];
  logic [31:0] eln_nxt [FREE_SLOTS];
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] didx_r, didx_nxt;
  logic [31:0] tail_r, tail_nxt;
  logic [31:0] rs_r, rs_nxt, re_r, re_nxt;
  logic [31:0] size_r, size_nxt, ins_s_r, ins_s_nxt, ins_l_r, ins_l_nxt;
  logic [31:0] ms_r, ms_nxt, ml_r, ml_nxt;
  logic [31:0] res_r, res_nxt;
  logic [1:0]  sts_r, sts_nxt;
  logic bad_r, bad_nxt, free_r, free_nxt, pend_r, pend_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [31:0] out_res_r, out_res_nxt;
  logic [1:0]  out_sts_r, out_sts_nxt;

  logic        cfg_wr;
  logic [32:0] sz_round;
  logic [31:0] rd_s, rd_l, newtail, mlen;
  logic        match, mhit, do_drop;
  logic [CW-1:0] drop_at;
  logic [CW-1:0] prev_idx;

  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_END) ? re_r : rs_r;

  assign sz_round = ({1'b0, in_data.req_size} + 33'd15) & ~33'h00000000F;
  assign rd_s = est_r[cur_r[IW-1:0]];
  assign rd_l = eln_r[cur_r[IW-1:0]];
  assign newtail = tail_r + size_r;
  assign match = (rd_s == tail_r);
  assign mhit = ({1'b0, ms_r} + {1'b0, ml_r}) == {1'b0, rd_s};
  assign mlen = ml_r + rd_l;
  assign prev_idx = cur_r - CW'(1);

  always_comb begin
    st.bad      = bad_r;
    st.is_free  = free_r;
    st.full     = (count_r == CW'(FREE_SLOTS));
    st.tail_ok  = ({1'b0, tail_r} + {1'b0, size_r}) < {1'b0, re_r};
    st.scan_end = (cur_r >= count_r);
    st.tmatch   = !st.scan_end && match;
    st.fit      = rd_l >= size_r;
    st.ple      = rd_s <= ins_s_r;
    st.need     = ({1'b0, newtail} + 33'd16) <= {1'b0, re_r};
    st.pend     = pend_r;
    st.out_free = !out_valid_r || out_ready;
  end

  // Drops come from a take (saved index) or from a merge (current index).
  assign do_drop = cmd.drop || (cmd.mstep && !st.scan_end && mhit);
  assign drop_at = cmd.drop ? didx_r : cur_r;

  always_comb begin
    count_nxt = count_r;
    cur_nxt = cur_r;
    didx_nxt = didx_r;
    tail_nxt = tail_r;
    rs_nxt = rs_r;
    re_nxt = re_r;
    size_nxt = size_r;
    ins_s_nxt = ins_s_r;
    ins_l_nxt = ins_l_r;
    ms_nxt = ms_r;
    ml_nxt = ml_r;
    res_nxt = res_r;
    sts_nxt = sts_r;
    bad_nxt = bad_r;
    free_nxt = free_r;
    pend_nxt = pend_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt = out_res_r;
    out_sts_nxt = out_sts_r;
    est_nxt = est_r;
    eln_nxt = eln_r;

    if (out_ready) out_valid_nxt = 1'b0;

    if (cfg_wr) begin
      if (paddr[2] == REG_START) rs_nxt = pwdata;
      else re_nxt = pwdata;
      tail_nxt = rs_nxt;
      est_nxt[0] = rs_nxt;
      eln_nxt[0] = re_nxt - rs_nxt;
      count_nxt = (re_nxt > rs_nxt) ? CW'(1) : '0;
    end

    if (cmd.load) begin
      size_nxt = sz_round[31:0];
      bad_nxt = (re_r == 32'd0) || (sz_round == 33'd0) || sz_round[32];
      free_nxt = (in_data.cmd == CMD_FREE);
      ins_s_nxt = in_data.block_address;
      ins_l_nxt = sz_round[31:0];
      pend_nxt = 1'b0;
      cur_nxt = '0;
      res_nxt = '0;
      sts_nxt = ST_DONE;
    end

    if (cmd.check) begin
      if (bad_r) sts_nxt = ST_BAD;
      else if (free_r && st.full) sts_nxt = ST_FULL;
    end

    if (cmd.tscan) begin
      if (!st.scan_end && !match) begin
        cur_nxt = cur_r + CW'(1);
      end else if (!st.tmatch && st.need && st.full) begin
        sts_nxt = ST_FULL;
      end else begin
        res_nxt = tail_r;
        tail_nxt = newtail;
        pend_nxt = st.need;
        ins_s_nxt = newtail;
        ins_l_nxt = re_r - newtail;
        didx_nxt = cur_r;
        cur_nxt = '0;
      end
    end

    if (cmd.fscan) begin
      if (st.scan_end) begin
        sts_nxt = ST_NOSPACE;
      end else if (st.fit) begin
        res_nxt = rd_s;
        didx_nxt = cur_r;
        pend_nxt = rd_l > size_r;
        ins_s_nxt = rd_s + size_r;
        ins_l_nxt = rd_l - size_r;
        if (tail_r == rd_s) tail_nxt = rd_s + size_r;
      end else begin
        cur_nxt = cur_r + CW'(1);
      end
    end

    if (do_drop) begin
      for (int k = 0; k < FREE_SLOTS - 1; k++) begin
        if (CW'(k) >= drop_at) begin
          est_nxt[k] = est_r[k + 1];
          eln_nxt[k] = eln_r[k + 1];
        end
      end
      count_nxt = count_r - CW'(1);
    end

    if (cmd.drop) cur_nxt = '0;

    if (cmd.pscan && !st.scan_end && st.ple) cur_nxt = cur_r + CW'(1);

    if (cmd.insert) begin
      for (int k = 1; k < FREE_SLOTS; k++) begin
        if (CW'(k) > cur_r) begin
          est_nxt[k] = est_r[k - 1];
          eln_nxt[k] = eln_r[k - 1];
        end
      end
      est_nxt[cur_r[IW-1:0]] = ins_s_r;
      eln_nxt[cur_r[IW-1:0]] = ins_l_r;
      count_nxt = count_r + CW'(1);
    end

    if (cmd.mstart) begin
      ms_nxt = est_r[0];
      ml_nxt = eln_r[0];
      cur_nxt = CW'(1);
    end

    if (cmd.mstep && !st.scan_end) begin
      if (mhit) begin
        eln_nxt[prev_idx[IW-1:0]] = mlen;
        ml_nxt = mlen;
        if (tail_r == rd_s) tail_nxt = ms_r;
      end else begin
        ms_nxt = rd_s;
        ml_nxt = rd_l;
        cur_nxt = cur_r + CW'(1);
      end
    end

    // The result word is copied out so the next command can use res_r and sts_r.
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      out_res_nxt = res_r;
      out_sts_nxt = sts_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      tail_r <= '0;
      rs_r <= '0;
      re_r <= '0;
      out_valid_r <= 1'b0;
      out_res_r <= '0;
      out_sts_r <= '0;
    end else begin
      count_r <= count_nxt;
      tail_r <= tail_nxt;
      rs_r <= rs_nxt;
      re_r <= re_nxt;
      out_valid_r <= out_valid_nxt;
      out_res_r <= out_res_nxt;
      out_sts_r <= out_sts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    est_r <= est_nxt;
    eln_r <= eln_nxt;
    cur_r <= cur_nxt;
    didx_r <= didx_nxt;
    size_r <= size_nxt;
    ins_s_r <= ins_s_nxt;
    ins_l_r <= ins_l_nxt;
    ms_r <= ms_nxt;
    ml_r <= ml_nxt;
    res_r <= res_nxt;
    sts_r <= sts_nxt;
    bad_r <= bad_nxt;
    free_r <= free_nxt;
    pend_r <= pend_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data.result_address = out_res_r;
  assign out_data.status = out_sts_r;

  `FEA_ASSERT(a_count_max, count_r <= CW'(FREE_SLOTS))
  `FEA_ASSERT(a_drop_nonempty, !do_drop || (count_r != '0))
  `FEA_ASSERT_NEXT(a_cfg_reinit, cfg_wr, count_r <= CW'(1) && tail_r == rs_r)
  `FEA_ASSERT_NEXT(a_finish_valid, cmd.finish, out_valid_r)
endmodule

// ----- design/free_extent_allocator_unit.sv -----
// Top level of the free extent allocator: sequencer plus extent datapath.
//
// One command word is handled at a time. A bad size, an uninitialized region
// or a free into a full table goes from the check straight to the result. An
// allocate runs the tail or first-fit search and then, if a remainder is left,
// the sorted-insert position search; a free runs the position search and then
// the coalescing walk, each visiting one table entry per cycle through the
// single read port of the extent table, while a removal or an insertion shifts
// the whole table at once. The result sits in an output register, so a new
// command is taken while it waits; its own result waits until the register is
// free. A write of either region register rebuilds the table in the same cycle.
module free_extent_allocator_unit import fea_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_word_t      in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output out_word_t     out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  ctl_cmd_t cmd;
  dp_stat_t st;

  assign pready = 1'b1;

  fea_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  fea_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
  );
endmodule
